// File: design/mpq_pkg.sv
// Shared types and codes for the min priority queue cell chain.
package mpq_pkg;

  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic compare;
    logic insert;
    logic remove;
    key_t key;
  } cell_ctl_t;

endpackage

// File: design/mpq_if.sv
// Request and response channel interfaces of the min priority queue.
interface mpq_req_if
  import mpq_pkg::*;
();
  logic valid;
  logic ready;
  logic func;
  key_t key_value;

  modport source (output valid, output func, output key_value, input ready);
  modport sink (input valid, input func, input key_value, output ready);
endinterface

interface mpq_rsp_if
  import mpq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;
  key_t                min_key;
  logic                is_empty;

  modport source (output valid, output status, output entry_count, output min_key,
                  output is_empty, input ready);
  modport sink (input valid, input status, input entry_count, input min_key,
                input is_empty, output ready);
endinterface

// File: design/mpq_cell.sv
// One slot of the sorted key chain: compare flags, insert and delete shifting.
module mpq_cell
  import mpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  key_t      left_key,
  input  logic      left_valid,
  input  logic      left_gt,
  input  key_t      right_key,
  input  logic      right_valid,
  output key_t      key,
  output logic      valid,
  output logic      gt,
  output logic      eq
);

  logic ge;
  key_t key_next;
  logic valid_next;

  always_comb begin
    key_next   = key;
    valid_next = valid;
    if (ctl.insert && gt) begin
      key_next   = left_gt ? left_key : ctl.key;
      valid_next = valid | left_valid;
    end else if (ctl.remove && ge) begin
      key_next   = right_key;
      valid_next = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      gt    <= 1'b0;
      ge    <= 1'b0;
      eq    <= 1'b0;
    end else begin
      valid <= valid_next;
      if (ctl.compare) begin
        gt <= !valid || (key > ctl.key);
        ge <= valid && (key >= ctl.key);
        eq <= valid && (key == ctl.key);
      end
    end
  end

endmodule

// File: design/min_priority_queue_insert_delete_unit.sv
// Top level: min priority queue built as a sorted chain of key cells.
//
// Usage:
//   req carries one operation per beat: func selects insert or delete of one
//   copy of key_value. rsp returns one beat per request with the status
//   (done, full, key not found), the count after the operation, the smallest
//   held key (zero when empty) and an empty flag.
//   Keys sit in a chain of CAPACITY cells kept in ascending order. Each cell
//   compares its key against the request key, then takes its left neighbor
//   (insert) or its right neighbor (delete) in the same cycle across the row.
// Timing:
//   An accepted beat passes through the compare step and then the apply
//   step; the response is valid on the cycle after apply. A new beat is
//   taken only back in idle, after the last one: accept, compare, apply,
//   set by the two-step cell update plus the handshake.
//   req stays ready while a response waits; if rsp is stalled the next beat
//   holds in its apply step until the pending response is taken.
// Reset:
//   rst clears all cell valid bits and the count, so the queue comes up empty.
module min_priority_queue_insert_delete_unit
  import mpq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic clk,
  input logic rst,
  mpq_req_if.sink   req,
  mpq_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t              state;
  state_t              state_next;
  logic                func;
  key_t                key_reg;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [STATUS_W-1:0] status;
  logic [STATUS_W-1:0] status_next;
  logic                rsp_valid;
  logic                rsp_valid_next;
  logic                out_free;
  logic                apply_go;
  logic                found;
  logic                full;
  logic [CNT_W+COUNT_W-1:0] count_wide;
  cell_ctl_t           ctl;

  key_t                cell_key [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_gt;
  logic [CAPACITY-1:0] cell_eq;

  assign out_free = !rsp_valid || rsp.ready;
  assign apply_go = (state == ST_APPLY) && out_free;
  assign found    = |cell_eq;
  assign full     = (count == CNT_W'(CAPACITY));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (req.valid) state_next = ST_COMPARE;
      ST_COMPARE: state_next = ST_APPLY;
      ST_APPLY:   if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.compare    = (state == ST_COMPARE);
    ctl.insert     = apply_go && (func == FUNC_INSERT) && !full;
    ctl.remove     = apply_go && (func == FUNC_DELETE) && found;
    ctl.key        = key_reg;
    req.ready      = (state == ST_IDLE);
    count_next     = count;
    status_next    = status;
    rsp_valid_next = rsp_valid && !rsp.ready;
    if (apply_go) begin
      rsp_valid_next = 1'b1;
      if (func == FUNC_INSERT) begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          status_next = STATUS_DONE;
          count_next  = count + 1'b1;
        end
      end else begin
        if (found) begin
          status_next = STATUS_DONE;
          count_next  = count - 1'b1;
        end else begin
          status_next = STATUS_MISSING;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
    if (req.valid && req.ready) begin
      func    <= req.func;
      key_reg <= req.key_value;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t l_key;
    logic l_valid;
    logic l_gt;
    key_t r_key;
    logic r_valid;

    if (i == 0) begin : g_head
      assign l_key   = '0;
      assign l_valid = 1'b1;
      assign l_gt    = 1'b0;
    end else begin : g_body
      assign l_key   = cell_key[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_gt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_key   = '0;
      assign r_valid = 1'b0;
    end else begin : g_link
      assign r_key   = cell_key[i+1];
      assign r_valid = cell_valid[i+1];
    end

    mpq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left_key    (l_key),
      .left_valid  (l_valid),
      .left_gt     (l_gt),
      .right_key   (r_key),
      .right_valid (r_valid),
      .key         (cell_key[i]),
      .valid       (cell_valid[i]),
      .gt          (cell_gt[i]),
      .eq          (cell_eq[i])
    );
  end

  assign count_wide      = {{COUNT_W{1'b0}}, count};
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = status;
  assign rsp.entry_count = count_wide[COUNT_W-1:0];
  assign rsp.min_key     = cell_valid[0] ? cell_key[0] : '0;
  assign rsp.is_empty    = !cell_valid[0];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("cell valid bits disagree with count");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (count == '0) == !cell_valid[0])
    else $error("head cell disagrees with empty count");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY && rsp_valid && !rsp.ready) |=> (state == ST_APPLY && $stable(count)))
    else $error("apply step advanced over a stalled response");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the min priority queue insert and delete unit.
module testbench
  import mpq_pkg::*;
;

  localparam int CAPACITY = 16;

  typedef struct {
    logic op;
    key_t key;
    int   rest_after;
    bit   drain_first;
  } queue_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
    key_t                min_key;
    logic                is_empty;
  } queue_view_t;

  logic clk;
  logic rst;

  mpq_req_if req_ch ();
  mpq_rsp_if rsp_ch ();

  min_priority_queue_insert_delete_unit #(.CAPACITY(CAPACITY)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  queue_op_t   stimulus_ops[$];
  queue_view_t pending_views[$];
  key_t        heap_keys[CAPACITY];
  int          heap_size = 0;
  int          mismatch_count = 0;
  int          rsp_beats = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          stall_draw;
  bit          req_fired = 0;
  bit          rsp_fired = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void heap_raise(int pos);
    key_t held;
    int   up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (heap_keys[pos] < heap_keys[up]) begin
        held = heap_keys[pos];
        heap_keys[pos] = heap_keys[up];
        heap_keys[up] = held;
        pos = up;
      end else begin
        break;
      end
    end
  endfunction

  function automatic queue_view_t apply_to_heap(logic op, key_t key);
    queue_view_t view;
    key_t        held;
    int          hole;
    int          pos;
    int          best;
    int          lchild;
    view.status = STATUS_DONE;
    if (op == FUNC_INSERT) begin
      if (heap_size >= CAPACITY) begin
        view.status = STATUS_FULL;
      end else begin
        heap_keys[heap_size] = key;
        heap_size++;
        heap_raise(heap_size - 1);
      end
    end else begin
      hole = -1;
      for (int i = 0; i < heap_size; i++) begin
        if (hole < 0 && heap_keys[i] == key) hole = i;
      end
      if (hole < 0) begin
        view.status = STATUS_MISSING;
      end else begin
        heap_size--;
        if (hole < heap_size) begin
          heap_keys[hole] = heap_keys[heap_size];
          heap_raise(hole);
          pos = hole;
          while (pos < heap_size) begin
            lchild = 2 * pos + 1;
            best = pos;
            if (lchild < heap_size && heap_keys[lchild] < heap_keys[best]) best = lchild;
            if (lchild + 1 < heap_size && heap_keys[lchild + 1] < heap_keys[best]) begin
              best = lchild + 1;
            end
            if (best == pos) break;
            held = heap_keys[pos];
            heap_keys[pos] = heap_keys[best];
            heap_keys[best] = held;
            pos = best;
          end
        end
      end
    end
    view.entry_count = heap_size[COUNT_W-1:0];
    view.min_key = (heap_size > 0) ? heap_keys[0] : '0;
    view.is_empty = (heap_size == 0);
    return view;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  task automatic queue_op(logic op, key_t key, int rest_after, bit drain_first);
    queue_op_t item;
    item.op = op;
    item.key = key;
    item.rest_after = rest_after;
    item.drain_first = drain_first;
    stimulus_ops.push_back(item);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fired) begin
      if (send_gap > 0) begin
        req_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (stimulus_ops.size() > 0 &&
                   !(stimulus_ops[0].drain_first && pending_views.size() != 0)) begin
        req_ch.valid <= 1'b1;
        req_ch.func <= stimulus_ops[0].op;
        req_ch.key_value <= stimulus_ops[0].key;
        send_gap <= stimulus_ops[0].rest_after;
        void'(stimulus_ops.pop_front());
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (rsp_fired) begin
      stall_draw = ((rsp_beats % 300) < 80) ? 0 : $urandom_range(0, 7);
      rsp_ch.ready <= (stall_draw == 0);
      stall_left <= (stall_draw == 0) ? 0 : stall_draw - 1;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    req_fired <= !rst && req_ch.valid && req_ch.ready;
    rsp_fired <= !rst && rsp_ch.valid && rsp_ch.ready;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      rsp_beats <= rsp_beats + 1;
      if (pending_views.size() == 0) begin
        $display("%0t: response beat with none expected: expected none, actual %0h %0h %0h %0h",
                 $time, rsp_ch.status, rsp_ch.entry_count, rsp_ch.min_key, rsp_ch.is_empty);
        mismatch_count++;
      end else begin
        check_field("status", pending_views[0].status, rsp_ch.status);
        check_field("entry_count", pending_views[0].entry_count, rsp_ch.entry_count);
        check_field("min_key", pending_views[0].min_key, rsp_ch.min_key);
        check_field("is_empty", pending_views[0].is_empty, rsp_ch.is_empty);
        void'(pending_views.pop_front());
      end
    end
    if (!rst && req_ch.valid && req_ch.ready) begin
      pending_views.push_back(apply_to_heap(req_ch.func, req_ch.key_value));
    end
  end

  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    key_t recent_keys[$];
    key_t key;
    int   insert_pct;
    int   pick;
    int   idx;
    int   rest;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_INSERT;
    req_ch.key_value = '0;
    rsp_ch.ready = 1'b0;

    queue_op(FUNC_DELETE, 32'sd5, 0, 0);
    queue_op(FUNC_INSERT, 32'sh7fff_ffff, 0, 0);
    queue_op(FUNC_INSERT, 32'sh8000_0000, 3, 0);
    queue_op(FUNC_INSERT, 32'sd0, 0, 0);
    queue_op(FUNC_INSERT, -32'sd1, 0, 0);
    queue_op(FUNC_INSERT, 32'sd7, 1, 0);
    queue_op(FUNC_INSERT, 32'sd7, 0, 0);
    queue_op(FUNC_DELETE, 32'sd7, 0, 0);
    queue_op(FUNC_DELETE, 32'sd5, 5, 0);
    queue_op(FUNC_DELETE, 32'sh8000_0000, 0, 0);
    for (int n = 0; n < 11; n++) queue_op(FUNC_INSERT, 32'sd100 - n * 37, 0, 0);
    queue_op(FUNC_INSERT, 32'sh8000_0000, 0, 0);
    queue_op(FUNC_DELETE, 32'sh7fff_ffff, 0, 0);
    queue_op(FUNC_DELETE, 32'sd100, 0, 1);

    for (int n = 0; n < 1625; n++) begin
      insert_pct = ((n / 40) % 3 == 0) ? 80 : ((n / 40) % 3 == 1) ? 25 : 55;
      rest = ((n / 150) % 3 == 0) ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 99) < insert_pct) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) key = $urandom();
        else if (pick < 8) key = $urandom_range(0, 8) - 4;
        else key = (pick == 8) ? 32'sh8000_0000 : 32'sh7fff_ffff;
        recent_keys.push_back(key);
        if (recent_keys.size() > 48) void'(recent_keys.pop_front());
        queue_op(FUNC_INSERT, key, rest, $urandom_range(0, 199) == 0);
      end else begin
        if (recent_keys.size() > 0 && $urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, recent_keys.size() - 1);
          key = recent_keys[idx];
          recent_keys.delete(idx);
        end else begin
          key = $urandom();
        end
        queue_op(FUNC_DELETE, key, rest, $urandom_range(0, 199) == 0);
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (stimulus_ops.size() == 0);
    @(posedge clk);
    wait (!req_ch.valid);
    wait (pending_views.size() == 0);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
